// ----- design/ngtm_pkg.sv -----
// ngtm_pkg: shared constants for the nearest glyph template matcher.
// Sizes, operation codes, register indexes and output constants.
// No dependencies.
package ngtm_pkg;

	localparam int MAX_SLOTS = 128;
	localparam int MAX_CELLS = 16;
	localparam int LUMA_BITS = 16;

	localparam int SLOT_W   = $clog2(MAX_SLOTS);
	localparam int CELL_W   = $clog2(MAX_CELLS);
	localparam int TMPL_AW  = SLOT_W + CELL_W;
	localparam int TMPL_DEPTH = MAX_SLOTS * MAX_CELLS;
	localparam int LETTER_W = 16;
	localparam int DIST_W   = 36;
	localparam int SQ_W     = 2 * LUMA_BITS;

	localparam logic [LETTER_W-1:0] SPACE_CODE = LETTER_W'(32);

	localparam logic [1:0] OP_TMPL   = 2'd0;
	localparam logic [1:0] OP_LETTER = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic CFG_CHAR_COUNT = 1'b0;
	localparam logic CFG_CELL_COUNT = 1'b1;

	localparam logic [7:0] CHAR_COUNT_RST = 8'd0;
	localparam logic [4:0] CELL_COUNT_RST = 5'd4;

endpackage

// ----- design/nearest_glyph_template_match_top.sv -----
// nearest_glyph_template_match_top: nearest glyph template matcher.
// Holds templates, letters and query lumas in three ngtm_ram instances.
// Depends on ngtm_pkg and ngtm_ram.
//
// Usage: an input word is taken at a clock edge with start high and busy low.
// Operation 0 writes one template cell, 1 writes a slot letter code, 2 writes
// one query cell; a query word with last high starts the match. The match
// walks slots 0..N-1 and, per slot, cells 0..max(C,1)-1 (N = saturated char_count,
// C = saturated cell_count), one template cell per cycle through the template
// RAM port, then a difference stage, a square stage and an accumulate/compare
// stage. busy stays high while the walk and these stages run, and the result
// strobe done is high for one cycle after the final slot compare. With no
// templates done follows in the next cycle with a space and found low.
// The result is shown once and is not held; the receiver cannot stall.
// Configuration writes (cfg_valid, always ready) take effect at the next
// starting word; a running walk keeps the counts it started with.
// Reset sets char_count to 0 and cell_count to 4; the RAMs keep no reset
// contents and need no clearing.
module nearest_glyph_template_match_top
	import ngtm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [CELL_W-1:0]    cell_req,
	input  logic [LUMA_BITS-1:0] luma,
	input  logic [LETTER_W-1:0]  letter_code,
	input  logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 done,
	output logic [LETTER_W-1:0]  best_letter,
	output logic [DIST_W-1:0]    best_distance,
	output logic                 found
);

	logic [7:0]           char_count_q;
	logic [4:0]           cell_count_q;
	logic                 walk_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CELL_W-1:0]    cell_q;
	logic [SLOT_W-1:0]    slots_m1_q;
	logic [CELL_W-1:0]    cells_m1_q;
	logic                 zero_q;

	logic                 v_s1, v_s2, v_s3;
	logic                 endslot_s1, endslot_s2, endslot_s3;
	logic                 endall_s1, endall_s2, endall_s3;
	logic                 kill_s1;
	logic [LUMA_BITS-1:0] diff_s2;
	logic [LETTER_W-1:0]  letter_s2, letter_s3;
	logic [SQ_W-1:0]      sq_s3;

	logic [DIST_W-1:0]    acc_q;
	logic [DIST_W-1:0]    best_dist_q;
	logic [LETTER_W-1:0]  best_letter_q;
	logic                 have_q;
	logic                 done_q;

	logic                 accept;
	logic                 go;
	logic [7:0]           slots_sat;
	logic [4:0]           cells_sat;
	logic                 cell_end;
	logic                 slot_end;
	logic [DIST_W-1:0]    sum;

	logic                 tmpl_we, letter_we, query_we;
	logic [TMPL_AW-1:0]   tmpl_addr;
	logic [SLOT_W-1:0]    letter_addr;
	logic [CELL_W-1:0]    query_addr;
	logic [LUMA_BITS-1:0] tmpl_rdata, query_rdata;
	logic [LETTER_W-1:0]  letter_rdata;

	assign busy      = walk_q | v_s1 | v_s2 | v_s3;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;
	assign go        = accept & (operation == OP_QUERY) & last;

	assign slots_sat = (char_count_q > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS) : char_count_q;
	assign cells_sat = (cell_count_q > 5'(MAX_CELLS)) ? 5'(MAX_CELLS) : cell_count_q;

	assign cell_end = (cell_q == cells_m1_q);
	assign slot_end = (slot_q == slots_m1_q);

	assign tmpl_we     = accept & (operation == OP_TMPL);
	assign letter_we   = accept & (operation == OP_LETTER);
	assign query_we    = accept & (operation == OP_QUERY);
	assign tmpl_addr   = walk_q ? {slot_q, cell_q} : {slot, cell_req};
	assign letter_addr = walk_q ? slot_q : slot;
	assign query_addr  = walk_q ? cell_q : cell_req;

	ngtm_ram #(.WIDTH(LUMA_BITS), .DEPTH(TMPL_DEPTH)) u_tmpl_ram (
		.clk   (clk),
		.we    (tmpl_we),
		.addr  (tmpl_addr),
		.wdata (luma),
		.rdata (tmpl_rdata)
	);

	ngtm_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_SLOTS)) u_letter_ram (
		.clk   (clk),
		.we    (letter_we),
		.addr  (letter_addr),
		.wdata (letter_code),
		.rdata (letter_rdata)
	);

	ngtm_ram #(.WIDTH(LUMA_BITS), .DEPTH(MAX_CELLS)) u_query_ram (
		.clk   (clk),
		.we    (query_we),
		.addr  (query_addr),
		.wdata (luma),
		.rdata (query_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= CHAR_COUNT_RST;
			cell_count_q <= CELL_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHAR_COUNT: char_count_q <= cfg_data;
				CFG_CELL_COUNT: cell_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// walk sequencer: one template cell read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q     <= 1'b0;
			slot_q     <= '0;
			cell_q     <= '0;
			slots_m1_q <= '0;
			cells_m1_q <= '0;
			zero_q     <= 1'b0;
		end else if (go) begin
			walk_q     <= (slots_sat != 8'd0);
			slot_q     <= '0;
			cell_q     <= '0;
			slots_m1_q <= SLOT_W'(slots_sat - 8'd1);
			cells_m1_q <= (cells_sat == 5'd0) ? '0 : CELL_W'(cells_sat - 5'd1);
			zero_q     <= (cells_sat == 5'd0);
		end else if (walk_q) begin
			if (cell_end) begin
				cell_q <= '0;
				slot_q <= slot_q + 1'b1;
				if (slot_end) begin
					walk_q <= 1'b0;
				end
			end else begin
				cell_q <= cell_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= walk_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		endslot_s1 <= cell_end;
		endall_s1  <= cell_end & slot_end;
		kill_s1    <= zero_q;

		endslot_s2 <= endslot_s1;
		endall_s2  <= endall_s1;
		letter_s2  <= letter_rdata;
		if (kill_s1) begin
			diff_s2 <= '0;
		end else if (query_rdata >= tmpl_rdata) begin
			diff_s2 <= query_rdata - tmpl_rdata;
		end else begin
			diff_s2 <= tmpl_rdata - query_rdata;
		end

		endslot_s3 <= endslot_s2;
		endall_s3  <= endall_s2;
		letter_s3  <= letter_s2;
		sq_s3      <= SQ_W'(diff_s2) * SQ_W'(diff_s2);
	end

	assign sum = acc_q + DIST_W'(sq_s3);

	// accumulate per slot, keep strictly smaller distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			have_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				acc_q  <= '0;
				have_q <= 1'b0;
				done_q <= (slots_sat == 8'd0);
			end else if (v_s3) begin
				if (endslot_s3) begin
					acc_q <= '0;
					if (!have_q || sum < best_dist_q) begin
						have_q <= 1'b1;
					end
				end else begin
					acc_q <= sum;
				end
				done_q <= endall_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			best_dist_q   <= '0;
			best_letter_q <= SPACE_CODE;
		end else if (v_s3 && endslot_s3 && (!have_q || sum < best_dist_q)) begin
			best_dist_q   <= sum;
			best_letter_q <= letter_s3;
		end
	end

	assign done          = done_q;
	assign best_letter   = best_letter_q;
	assign best_distance = best_dist_q;
	assign found         = have_q;

`ifndef SYNTHESIS
	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !walk_q && !v_s1 && !v_s2 && !v_s3)
		else $error("result strobe while the walk is still running");

	a_done_follows_end: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && endall_s3 |=> done)
		else $error("final slot compare gave no result strobe");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && endslot_s3 |=> acc_q == '0)
		else $error("slot accumulator not cleared at slot end");

	a_found_on_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> $past(v_s3))
		else $error("found without a compared template");
`endif

endmodule

// ----- design/ngtm_ram.sv -----
// ngtm_ram: generic single-port synchronous RAM with registered read.
// Width and depth set by parameters; no other dependencies.
module ngtm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- verif/nearest_glyph_template_match_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nearest_glyph_template_match_top: a scoreboard class
// predicts each nearest-template match, plain tasks drive words and register writes.
// Depends on ngtm_pkg and the matcher RTL.
import ngtm_pkg::*;

localparam logic [1:0] OP_UNUSED = 2'd3;

typedef struct {
	logic [1:0]           op;
	logic [SLOT_W-1:0]    slot;
	logic [CELL_W-1:0]    cell_idx;
	logic [LUMA_BITS-1:0] luma;
	logic [LETTER_W-1:0]  code;
	logic                 last;
} glyph_word_t;

typedef struct packed {
	logic [LETTER_W-1:0] letter;
	logic [DIST_W-1:0]   distance;
	logic                found;
} glyph_match_t;

class glyph_match_scoreboard;
	logic [LUMA_BITS-1:0] tmpl [0:TMPL_DEPTH-1];
	logic [LETTER_W-1:0]  letters [0:MAX_SLOTS-1];
	logic [LUMA_BITS-1:0] query [0:MAX_CELLS-1];
	logic [7:0]           char_cnt;
	logic [4:0]           cell_cnt;
	glyph_match_t         pending [$];
	int                   failures;
	int                   words_seen;
	int                   results_checked;
	int                   tied_matches;

	function new();
		char_cnt = CHAR_COUNT_RST;
		cell_cnt = CELL_COUNT_RST;
		failures = 0;
		words_seen = 0;
		results_checked = 0;
		tied_matches = 0;
	endfunction

	function void configure(logic idx, logic [7:0] data);
		if (idx == CFG_CHAR_COUNT) begin
			char_cnt = data;
		end else begin
			cell_cnt = data[4:0];
		end
	endfunction

	function glyph_match_t nearest_template();
		glyph_match_t res;
		int slots, cells;
		logic [39:0] sum, best, sat;
		logic [LUMA_BITS-1:0] a, b, d;
		logic [LETTER_W-1:0] code;
		bit have, tie;
		slots = (char_cnt > MAX_SLOTS) ? MAX_SLOTS : char_cnt;
		cells = (cell_cnt > MAX_CELLS) ? MAX_CELLS : cell_cnt;
		sat = (40'd1 << DIST_W) - 40'd1;
		best = '0;
		code = SPACE_CODE;
		have = 0;
		tie = 0;
		for (int s = 0; s < slots; s++) begin
			sum = '0;
			for (int c = 0; c < cells; c++) begin
				a = query[c];
				b = tmpl[s * MAX_CELLS + c];
				d = (a >= b) ? a - b : b - a;
				sum = sum + 40'(d) * 40'(d);
			end
			if (have && sum == best)
				tie = 1;
			if (!have || sum < best) begin
				have = 1;
				best = sum;
				code = letters[s];
				tie = 0;
			end
		end
		if (tie)
			tied_matches++;
		if (best > sat)
			best = sat;
		res.letter = code;
		res.distance = have ? best[DIST_W-1:0] : '0;
		res.found = have;
		return res;
	endfunction

	function void note_word(glyph_word_t w);
		words_seen++;
		case (w.op)
			OP_TMPL: tmpl[{w.slot, w.cell_idx}] = w.luma;
			OP_LETTER: letters[w.slot] = w.code;
			OP_QUERY: begin
				query[w.cell_idx] = w.luma;
				if (w.last)
					pending.insert(pending.size(), nearest_template());
			end
			default: ;
		endcase
	endfunction

	function void check_result(logic [LETTER_W-1:0] letter, logic [DIST_W-1:0] got_dist,
			logic got_found);
		glyph_match_t exp_res;
		if (pending.size() == 0) begin
			$error("unexpected result: best_letter %0h best_distance %0h found %0b",
				letter, got_dist, got_found);
			failures++;
			return;
		end
		exp_res = pending.pop_front();
		results_checked++;
		if (letter !== exp_res.letter) begin
			$error("best_letter: expected %0h, got %0h", exp_res.letter, letter);
			failures++;
		end
		if (got_dist !== exp_res.distance) begin
			$error("best_distance: expected %0h, got %0h", exp_res.distance, got_dist);
			failures++;
		end
		if (got_found !== exp_res.found) begin
			$error("found: expected %0b, got %0b", exp_res.found, got_found);
			failures++;
		end
	endfunction
endclass

module nearest_glyph_template_match_top_tb;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int MAX_GAP = 40;
	localparam int FULL_SLOTS = 12;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           operation;
	logic [SLOT_W-1:0]    slot;
	logic [CELL_W-1:0]    cell_req;
	logic [LUMA_BITS-1:0] luma;
	logic [LETTER_W-1:0]  letter_code;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_index;
	logic [7:0]           cfg_data;
	logic                 done;
	logic [LETTER_W-1:0]  best_letter;
	logic [DIST_W-1:0]    best_distance;
	logic                 found;

	glyph_match_scoreboard ledger = new();
	int unsigned cycle_count = 0;
	int idle_pct = 0;
	bit burst = 0;
	int settings_used = 0;
	int idle_modes [4] = '{0, 86, 0, 29};

	nearest_glyph_template_match_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.slot(slot),
		.cell_req(cell_req),
		.luma(luma),
		.letter_code(letter_code),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.best_letter(best_letter),
		.best_distance(best_distance),
		.found(found)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** nearest_glyph_template_match_top: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_result(best_letter, best_distance, found);
	end

	function automatic logic [LUMA_BITS-1:0] pick_luma();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return LUMA_BITS'($urandom);
		endcase
	endfunction

	function automatic glyph_word_t random_word();
		glyph_word_t w;
		w.op = 2'($urandom);
		w.slot = SLOT_W'($urandom);
		w.cell_idx = CELL_W'($urandom);
		w.luma = pick_luma();
		w.code = LETTER_W'($urandom);
		w.last = 1'($urandom);
		return w;
	endfunction

	function automatic glyph_word_t mk(logic [1:0] op, int s, int c, logic [LUMA_BITS-1:0] l,
			logic [LETTER_W-1:0] code, logic lst);
		glyph_word_t w;
		w.op = op;
		w.slot = SLOT_W'(s);
		w.cell_idx = CELL_W'(c);
		w.luma = l;
		w.code = code;
		w.last = lst;
		return w;
	endfunction

	task automatic send_word(glyph_word_t w);
		start <= 1'b1;
		operation <= w.op;
		slot <= w.slot;
		cell_req <= w.cell_idx;
		luma <= w.luma;
		letter_code <= w.code;
		last <= w.last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ledger.note_word(w);
		@(negedge clk);
	endtask

	task automatic issue(glyph_word_t w);
		int gap;
		gap = 0;
		while (!burst && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
			gap++;
		end
		send_word(w);
	endtask

	// hold off until every match has reported and the block is idle
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (ledger.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic set_config(logic [7:0] chars, logic [4:0] cells);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CHAR_COUNT;
		cfg_data <= chars;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ledger.configure(CFG_CHAR_COUNT, chars);
		@(negedge clk);
		cfg_index <= CFG_CELL_COUNT;
		cfg_data <= {3'b000, cells};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ledger.configure(CFG_CELL_COUNT, {3'b000, cells});
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_phase(logic [7:0] chars, logic [4:0] cells, int items);
		glyph_word_t w;
		int sent, n_cells, n_slots, k, pattern, r;
		logic [LUMA_BITS-1:0] ref_luma;
		set_config(chars, cells);
		n_cells = (cells > MAX_CELLS) ? MAX_CELLS : cells;
		n_slots = (chars > MAX_SLOTS) ? MAX_SLOTS : chars;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(0, 99);
			w = random_word();
			if (r < 70) begin
				burst = ($urandom_range(0, 7) == 0);
				k = (n_slots > 0) ? $urandom_range(0, n_slots - 1) : $urandom_range(0, MAX_SLOTS - 1);
				pattern = $urandom_range(0, 2);
				if (n_cells == 0) begin
					w.op = OP_QUERY;
					w.last = 1'b1;
					issue(w);
					sent++;
				end else begin
					for (int c = 0; c < n_cells; c++) begin
						w = random_word();
						w.op = OP_QUERY;
						w.cell_idx = CELL_W'(c);
						w.last = (c == n_cells - 1);
						ref_luma = ledger.tmpl[k * MAX_CELLS + c];
						if (!$isunknown(ref_luma)) begin
							if (pattern == 0)
								w.luma = ref_luma;
							else if (pattern == 1)
								w.luma = ref_luma + LUMA_BITS'($urandom_range(0, 15));
						end
						issue(w);
						sent++;
					end
				end
			end else if (r < 85) begin
				w.op = OP_TMPL;
				if (n_slots > 0) begin
					w.slot = SLOT_W'($urandom_range(0, n_slots - 1));
					k = $urandom_range(0, n_slots - 1);
					ref_luma = ledger.tmpl[k * MAX_CELLS + w.cell_idx];
					// copy a cell of another slot now and then to force ties
					if ($urandom_range(0, 3) == 0 && !$isunknown(ref_luma))
						w.luma = ref_luma;
				end
				issue(w);
				sent++;
			end else if (r < 93) begin
				w.op = OP_LETTER;
				issue(w);
				sent++;
			end else if (r < 97) begin
				w.op = OP_QUERY;
				w.last = 1'b0;
				issue(w);
				sent++;
			end else begin
				w.op = OP_UNUSED;
				issue(w);
			end
		end
		burst = 0;
		settle();
	endtask

	initial begin
		int code;
		logic [7:0] chars;
		logic [4:0] cells;
		int items;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_TMPL;
		slot = '0;
		cell_req = '0;
		luma = '0;
		letter_code = '0;
		last = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CHAR_COUNT;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: no templates in use
		issue(mk(OP_QUERY, 0, 5, 16'hFFFF, 16'h0000, 1'b1));
		issue(mk(OP_UNUSED, 127, 15, 16'hFFFF, 16'hFFFF, 1'b1));
		issue(mk(OP_QUERY, 3, 9, 16'h0000, 16'hFFFF, 1'b0));

		// load every cell of the low slots, cell 0 of the rest, every letter and query cell
		code = $urandom_range(33, 100);
		for (int s = 0; s < MAX_SLOTS; s++) begin
			for (int c = 0; c < MAX_CELLS; c++)
				if (s < FULL_SLOTS || c == 0)
					send_word(mk(OP_TMPL, s, c, pick_luma(), LETTER_W'($urandom),
						1'($urandom)));
			send_word(mk(OP_LETTER, s, $urandom_range(0, 15), pick_luma(), LETTER_W'(code),
				1'($urandom)));
			code += $urandom_range(1, 300);
		end
		for (int c = 0; c < MAX_CELLS; c++)
			send_word(mk(OP_QUERY, $urandom_range(0, 127), c, pick_luma(), 16'h0000, 1'b0));

		// ties, zero distance and full-scale differences on three slots
		settle();
		set_config(8'd3, 5'd2);
		issue(mk(OP_TMPL, 0, 0, 16'hFFFF, 16'h0000, 1'b0));
		issue(mk(OP_TMPL, 0, 1, 16'hFFFF, 16'h0000, 1'b0));
		issue(mk(OP_TMPL, 1, 0, 16'h0000, 16'hFFFF, 1'b1));
		issue(mk(OP_TMPL, 1, 1, 16'h0000, 16'h0000, 1'b0));
		issue(mk(OP_TMPL, 2, 0, 16'h0000, 16'h0000, 1'b0));
		issue(mk(OP_TMPL, 2, 1, 16'h0000, 16'h0000, 1'b0));
		issue(mk(OP_LETTER, 0, 0, 16'h0000, 16'h0041, 1'b0));
		issue(mk(OP_LETTER, 1, 0, 16'hFFFF, 16'hFFFF, 1'b1));
		issue(mk(OP_LETTER, 2, 0, 16'h0000, 16'h0000, 1'b0));
		issue(mk(OP_QUERY, 0, 0, 16'h0000, 16'h0000, 1'b0));
		issue(mk(OP_QUERY, 0, 1, 16'h0000, 16'h0000, 1'b1));
		issue(mk(OP_QUERY, 0, 1, 16'hFFFF, 16'h0000, 1'b1));
		issue(mk(OP_QUERY, 0, 0, 16'hFFFF, 16'h0000, 1'b1));
		settle();
		set_config(8'd3, 5'd0);
		issue(mk(OP_QUERY, 0, 15, 16'h1234, 16'h0000, 1'b1));
		settle();

		for (int p = 0; p < 16; p++) begin
			idle_pct = idle_modes[p % 4];
			chars = 8'($urandom_range(1, FULL_SLOTS));
			cells = 5'($urandom_range(1, 16));
			items = 60;
			case (p)
				3: begin chars = 8'd128; cells = 5'd1; items = 40; end
				5: begin chars = 8'd0; items = 80; end
				7: begin chars = 8'(FULL_SLOTS); cells = 5'd31; items = 40; end
				9: begin cells = 5'd0; items = 80; end
				11: begin chars = 8'd200; cells = 5'd1; items = 60; end
				14: cells = 5'd16;
				default: ;
			endcase
			run_phase(chars, cells, items);
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Covered %0d accepted words under %0d register settings.",
			ledger.words_seen, settings_used);
		$display("Checked %0d match results, %0d of them with tied distances.",
			ledger.results_checked, ledger.tied_matches);
		if (ledger.failures == 0 && ledger.pending.size() == 0) begin
			$display("** nearest_glyph_template_match_top: PASSED **");
		end else begin
			$display("** nearest_glyph_template_match_top: FAILED **");
		end
		$finish;
	end
endmodule
